// ----- hw/rtl/i2cm_seq_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq_pkg
// shared types and constants of the i2c master transfer sequencer
// ----------------------------------------------------------------------------
package i2cm_seq_pkg;

   // request commands
   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_STATUS = 2'd3
   } cmd_type;

   // bus actions handed back
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_STOP    = 3'd2,
      ACT_TX      = 3'd3,
      ACT_RX_ACK  = 3'd4,
      ACT_RX_NACK = 3'd5
   } act_type;

   // twi status codes, upper five bits only (low three bits are prescaler)
   localparam logic [4:0] ST_START        = 5'h01; // 0x08
   localparam logic [4:0] ST_REP_START    = 5'h02; // 0x10
   localparam logic [4:0] ST_MT_SLA_ACK   = 5'h03; // 0x18
   localparam logic [4:0] ST_MT_SLA_NACK  = 5'h04; // 0x20
   localparam logic [4:0] ST_MT_DATA_ACK  = 5'h05; // 0x28
   localparam logic [4:0] ST_MT_DATA_NACK = 5'h06; // 0x30
   localparam logic [4:0] ST_ARB_LOST     = 5'h07; // 0x38
   localparam logic [4:0] ST_MR_SLA_ACK   = 5'h08; // 0x40
   localparam logic [4:0] ST_MR_SLA_NACK  = 5'h09; // 0x48
   localparam logic [4:0] ST_MR_DATA_ACK  = 5'h0A; // 0x50
   localparam logic [4:0] ST_MR_DATA_NACK = 5'h0B; // 0x58

   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;
   localparam logic [4:0] RETRIES_MAX       = 5'd31;

endpackage

// ----- hw/rtl/i2cm_seq_ifs.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq channel interfaces
// valid/ready channels for requests and responses
// ----------------------------------------------------------------------------
interface i2cm_seq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [6:0] slave_address;
   logic [7:0] byte_count;
   logic [7:0] load_index;
   logic [7:0] load_byte;
   logic [7:0] status_code;
   logic [7:0] rx_byte;

   modport source (
      output valid, cmd, slave_address, byte_count, load_index, load_byte,
             status_code, rx_byte,
      input  ready
   );
   modport sink (
      input  valid, cmd, slave_address, byte_count, load_index, load_byte,
             status_code, rx_byte,
      output ready
   );
endinterface

interface i2cm_seq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] tx_byte;
   logic       rx_valid;
   logic [7:0] rx_index;
   logic [7:0] rx_data;
   logic       busy_res;
   logic       error;
   logic       rejected;

   modport source (
      output valid, action, tx_byte, rx_valid, rx_index, rx_data, busy_res,
             error, rejected,
      input  ready
   );
   modport sink (
      input  valid, action, tx_byte, rx_valid, rx_index, rx_data, busy_res,
             error, rejected,
      output ready
   );
endinterface

// ----- hw/rtl/i2cm_seq_ram.sv -----
// ----------------------------------------------------------------------------
// i2cm_seq_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module i2cm_seq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/i2c_master_transfer_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// master-side i2c transfer sequencer: at most one bus action per request beat
// ----------------------------------------------------------------------------
//
//  port       | dir | role
//  -----------+-----+------------------------------------------------------
//  req_chan   | in  | load byte / start write / start read / status event
//  rsp_chan   | out | bus action, tx byte, rx byte with index, flags
//  csr_wr_*   | in  | retry_limit write, 4 bits, reset value 3
//
//  one request beat per clock while req ready is high; its response beat is valid the next cycle
//  the write buffer ram has a registered read port, the pointer read is
//  issued with every accepted beat and the data meets the response stage
//  req ready = response stage empty or being taken, so the request side
//  is held only for the cycles in which a response beat waits
//  synchronous reset clears all control state; the buffer is not cleared
//
module i2c_master_transfer_sequencer_top #(
   parameter int BUF_DEPTH = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   i2cm_seq_req_if.sink         req_chan,
   i2cm_seq_rsp_if.source       rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [3:0]           csr_wr_data
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   // transfer state
   logic [3:0]        retry_limit_ff;
   logic [7:0]        target_ff,  target_in;
   logic signed [8:0] left_ff,    left_in;
   logic [7:0]        pos_ff,     pos_in;
   logic [AW-1:0]     rd_ptr_ff,  rd_ptr_in;   // pos mod buffer depth
   logic [4:0]        retries_ff, retries_in;
   logic              busy_ff,    busy_in;
   logic              error_ff,   error_in;

   // response stage
   logic              rsp_valid_ff;
   i2cm_seq_pkg::act_type act_ff, act_in;
   logic [7:0]        tx_ff,      tx_in;
   logic              use_mem_ff, use_mem_in;  // tx byte comes from the buffer
   logic              rxv_ff,     rxv_in;
   logic [7:0]        rxi_ff,     rxi_in;
   logic [7:0]        rxd_ff,     rxd_in;
   logic              rej_ff,     rej_in;
   logic              busy_res_ff;
   logic              error_res_ff;

   logic              accept;
   logic              buf_wr_en;
   logic [7:0]        buf_rd_data;
   logic [4:0]        st_code;
   logic signed [8:0] left_dec;
   i2cm_seq_pkg::cmd_type cmd;

   assign cmd     = i2cm_seq_pkg::cmd_type'(req_chan.cmd);
   assign st_code = req_chan.status_code[7:3];

   // response stage empty or draining this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // loads beyond the buffer are dropped
   assign buf_wr_en = accept && (cmd == i2cm_seq_pkg::CMD_LOAD) &&
                      ({1'b0, req_chan.load_index} < 9'(BUF_DEPTH));

   i2cm_seq_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH),
      .ADDR_W(AW)
   ) u_wbuf (
      .clock  (clock),
      .wr_en  (buf_wr_en),
      .wr_addr(req_chan.load_index[AW-1:0]),
      .wr_data(req_chan.load_byte),
      .rd_en  (accept),
      .rd_addr(rd_ptr_ff),
      .rd_data(buf_rd_data)
   );

   // count decrement saturating at -1
   assign left_dec = (left_ff == -9'sd1) ? left_ff : left_ff - 9'sd1;

   always_comb begin
      target_in  = target_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      rd_ptr_in  = rd_ptr_ff;
      retries_in = retries_ff;
      busy_in    = busy_ff;
      error_in   = error_ff;
      act_in     = i2cm_seq_pkg::ACT_NONE;
      tx_in      = 8'h00;
      use_mem_in = 1'b0;
      rxv_in     = 1'b0;
      rxi_in     = 8'h00;
      rxd_in     = 8'h00;
      rej_in     = 1'b0;

      case (cmd)
         i2cm_seq_pkg::CMD_LOAD: begin
            // buffer write happens in the ram
         end
         i2cm_seq_pkg::CMD_WRITE, i2cm_seq_pkg::CMD_READ: begin
            if (busy_ff) begin
               rej_in = 1'b1;
            end else begin
               target_in  = {req_chan.slave_address, cmd == i2cm_seq_pkg::CMD_READ};
               left_in    = {1'b0, req_chan.byte_count};
               pos_in     = 8'h00;
               rd_ptr_in  = '0;
               retries_in = 5'd0;
               busy_in    = 1'b1;
               act_in     = i2cm_seq_pkg::ACT_START;
            end
         end
         i2cm_seq_pkg::CMD_STATUS: begin
            if (busy_ff) begin
               case (st_code)
                  i2cm_seq_pkg::ST_START: begin
                     act_in = i2cm_seq_pkg::ACT_TX;
                     tx_in  = target_ff;
                  end
                  i2cm_seq_pkg::ST_REP_START: begin
                     if (retries_ff > {1'b0, retry_limit_ff}) begin
                        act_in  = i2cm_seq_pkg::ACT_STOP;
                        busy_in = 1'b0;
                     end else begin
                        act_in = i2cm_seq_pkg::ACT_TX;
                        tx_in  = target_ff;
                     end
                  end
                  i2cm_seq_pkg::ST_MT_SLA_ACK: begin
                     // count prefix byte
                     retries_in = 5'd0;
                     act_in     = i2cm_seq_pkg::ACT_TX;
                     tx_in      = left_ff[7:0];
                  end
                  i2cm_seq_pkg::ST_MT_SLA_NACK, i2cm_seq_pkg::ST_MR_SLA_NACK: begin
                     if (retries_ff != i2cm_seq_pkg::RETRIES_MAX) begin
                        retries_in = retries_ff + 5'd1;
                     end
                     act_in = i2cm_seq_pkg::ACT_START;
                  end
                  i2cm_seq_pkg::ST_MT_DATA_ACK: begin
                     if (left_ff >= 9'sd1) begin
                        left_in    = left_ff - 9'sd1;
                        act_in     = i2cm_seq_pkg::ACT_TX;
                        use_mem_in = 1'b1;
                        pos_in     = pos_ff + 8'd1;
                        // the 8-bit position wraps to entry zero as well
                        rd_ptr_in  = (pos_ff == 8'hFF ||
                                      rd_ptr_ff == AW'(BUF_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + 1'b1;
                     end else begin
                        left_in = -9'sd1;
                        act_in  = i2cm_seq_pkg::ACT_STOP;
                        busy_in = 1'b0;
                     end
                  end
                  i2cm_seq_pkg::ST_MT_DATA_NACK, i2cm_seq_pkg::ST_ARB_LOST: begin
                     act_in   = i2cm_seq_pkg::ACT_STOP;
                     busy_in  = 1'b0;
                     error_in = 1'b1;
                  end
                  i2cm_seq_pkg::ST_MR_SLA_ACK: begin
                     left_in = left_dec;
                     act_in  = (left_dec > 9'sd0) ? i2cm_seq_pkg::ACT_RX_ACK
                                                  : i2cm_seq_pkg::ACT_RX_NACK;
                  end
                  i2cm_seq_pkg::ST_MR_DATA_ACK: begin
                     rxv_in    = 1'b1;
                     rxi_in    = pos_ff;
                     rxd_in    = req_chan.rx_byte;
                     pos_in    = pos_ff + 8'd1;
                     rd_ptr_in = (pos_ff == 8'hFF ||
                                  rd_ptr_ff == AW'(BUF_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + 1'b1;
                     left_in   = left_dec;
                     act_in    = (left_dec > 9'sd0) ? i2cm_seq_pkg::ACT_RX_ACK
                                                    : i2cm_seq_pkg::ACT_RX_NACK;
                  end
                  i2cm_seq_pkg::ST_MR_DATA_NACK: begin
                     rxv_in  = 1'b1;
                     rxi_in  = pos_ff;
                     rxd_in  = req_chan.rx_byte;
                     act_in  = i2cm_seq_pkg::ACT_STOP;
                     busy_in = 1'b0;
                  end
                  default: begin
                     // unknown status code, nothing happens
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff <= i2cm_seq_pkg::RETRY_LIMIT_RESET;
         target_ff      <= 8'h00;
         left_ff        <= 9'sd0;
         pos_ff         <= 8'h00;
         rd_ptr_ff      <= '0;
         retries_ff     <= 5'd0;
         busy_ff        <= 1'b0;
         error_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            retry_limit_ff <= csr_wr_data;
         end
         if (accept) begin
            target_ff  <= target_in;
            left_ff    <= left_in;
            pos_ff     <= pos_in;
            rd_ptr_ff  <= rd_ptr_in;
            retries_ff <= retries_in;
            busy_ff    <= busy_in;
            error_ff   <= error_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff       <= act_in;
         tx_ff        <= tx_in;
         use_mem_ff   <= use_mem_in;
         rxv_ff       <= rxv_in;
         rxi_ff       <= rxi_in;
         rxd_ff       <= rxd_in;
         rej_ff       <= rej_in;
         busy_res_ff  <= busy_in;
         error_res_ff <= error_in;
      end
   end

   // ram read data holds while no beat is accepted, so a stall keeps it
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.action   = act_ff;
   assign rsp_chan.tx_byte  = use_mem_ff ? buf_rd_data : tx_ff;
   assign rsp_chan.rx_valid = rxv_ff;
   assign rsp_chan.rx_index = rxi_ff;
   assign rsp_chan.rx_data  = rxd_ff;
   assign rsp_chan.busy_res = busy_res_ff;
   assign rsp_chan.error    = error_res_ff;
   assign rsp_chan.rejected = rej_ff;

   // error flag is sticky until reset
   a_error_sticky : assert property (@(posedge clock) disable iff (reset)
      error_ff |=> error_ff)
      else $error("error flag dropped without reset");

   // a start while idle makes the block busy
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (accept && !busy_ff && (cmd == i2cm_seq_pkg::CMD_WRITE ||
                              cmd == i2cm_seq_pkg::CMD_READ))
      |=> (busy_ff && rsp_chan.action == i2cm_seq_pkg::ACT_START))
      else $error("start beat did not open a transfer");

   // a start while busy comes back rejected with no action
   a_start_reject : assert property (@(posedge clock) disable iff (reset)
      (accept && busy_ff && (cmd == i2cm_seq_pkg::CMD_WRITE ||
                             cmd == i2cm_seq_pkg::CMD_READ))
      |=> (rsp_chan.valid && rsp_chan.rejected &&
           rsp_chan.action == i2cm_seq_pkg::ACT_NONE))
      else $error("start while busy not rejected");

   // read pointer stays inside the buffer
   a_ptr_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, rd_ptr_ff} < (AW + 1)'(BUF_DEPTH))
      else $error("buffer read pointer out of range");

   // busy reported with a response matches the live flag
   a_busy_match : assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_chan.busy_res == busy_ff))
      else $error("response busy flag differs from state");

endmodule
